>>> rtl/rmrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrb_pkg
// Shared types and constants of the RGB565 to mono raster band encoder.
// ----------------------------------------------------------------------------
package rmrb_pkg;

  localparam int MaxWidth = 1024;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam int PixW   = 16;
  localparam int WidthW = 11;
  localparam int HeightW = 12;
  localparam int BandW  = 8;
  localparam int ColW   = 10;
  localparam int CfgW   = 12;
  localparam int LumaW  = 18;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd384;
  localparam logic [HeightW-1:0] HeightReset = 12'd220;
  localparam logic [BandW-1:0]   BandReset   = 8'd24;

  localparam logic [LumaW-1:0] LumaR = 18'd299;
  localparam logic [LumaW-1:0] LumaG = 18'd587;
  localparam logic [LumaW-1:0] LumaB = 18'd114;
  // luma / 1000 < 128  <=>  weighted sum < 128000
  localparam logic [LumaW-1:0] BlackLimit = 18'd128000;

  localparam logic [7:0] HdrGs   = 8'h1D;
  localparam logic [7:0] HdrV    = 8'h76;
  localparam logic [7:0] HdrMode = 8'h30;
  localparam logic [7:0] HdrZero = 8'h00;
  localparam logic [3:0] HdrLen  = 4'd8;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BAND_HEIGHT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    HB_GS    = 3'd0,
    HB_V     = 3'd1,
    HB_MODE  = 3'd2,
    HB_M     = 3'd3,
    HB_XL    = 3'd4,
    HB_XH    = 3'd5,
    HB_YL    = 3'd6,
    HB_YH    = 3'd7
  } hdr_byte_e;

  // One classified request: optional band header, optional data byte.
  typedef struct packed {
    logic       hdr;
    logic [7:0] bpr;
    logic [7:0] rows;
    logic       dat;
    logic [7:0] data;
    logic       band_end;
    logic       image_end;
  } rmrb_entry_t;

endpackage
`default_nettype wire

>>> rtl/rgb565_to_mono_raster_band.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb565_to_mono_raster_band
// RGB565 pixels in, GS v 0 raster band byte stream out.
// ----------------------------------------------------------------------------
// A data byte or first header byte passes through the request queue and the
// output register. Throughput: 1 pixel per cycle while the queue is not full;
// each band adds 8 header bytes on the output side, absorbed by a 4-request
// queue when rows span a full byte; rows of under 8 dots can stall the input
// per band. Output is 1 byte/cycle while out_stall_i is low. Reset: width 384,
// height 220, band 24; position counters, queue and output valid cleared.
module rgb565_to_mono_raster_band import rmrb_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic [PixW-1:0] pixel_i,
  input  wire logic            pixel_valid_i,
  output logic                 pixel_stall_o,
  output logic [7:0]           out_byte_o,
  output logic                 band_end_o,
  output logic                 image_end_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i
);

  logic [WidthW-1:0]  image_width_q;
  logic [HeightW-1:0] image_height_q;
  logic [BandW-1:0]   band_height_q;

  logic        push, full, pop, empty;
  rmrb_entry_t wentry, rentry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
      band_height_q  <= BandReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[WidthW-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[HeightW-1:0];
        REG_BAND_HEIGHT:  band_height_q  <= cfg_data_i[BandW-1:0];
        default: ;
      endcase
    end
  end

  rmrb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_i        (pixel_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_stall_o  (pixel_stall_o),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .band_height_i  (band_height_q),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (wentry)
  );

  rmrb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rentry)
  );

  rmrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (rentry),
    .pop_o       (pop),
    .out_byte_o  (out_byte_o),
    .band_end_o  (band_end_o),
    .image_end_o (image_end_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

>>> rtl/rmrb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrb_front
// Takes pixels, thresholds luma, packs dots and tracks row/band position.
// ----------------------------------------------------------------------------
module rmrb_front import rmrb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [PixW-1:0]    pixel_i,
  input  wire logic               pixel_valid_i,
  output logic                    pixel_stall_o,
  input  wire logic [WidthW-1:0]  image_width_i,
  input  wire logic [HeightW-1:0] image_height_i,
  input  wire logic [BandW-1:0]   band_height_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output rmrb_entry_t             entry_o
);

  logic [ColW-1:0]    col_q, col_d;
  logic [BandW-1:0]   row_q, row_d;
  logic [HeightW-1:0] rows_done_q, rows_done_d;
  logic [BandW-1:0]   cbr_q, cbr_d;
  logic [7:0]         pack_q, pack_d;
  logic [2:0]         bits_q, bits_d;

  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [BandW-1:0]   bh_eff;
  logic               accept, start, black, row_end, emit, be, ie;
  logic [LumaW-1:0]   luma_sum;
  logic [HeightW-1:0] rows_base, remaining, rows_inc;
  logic [BandW-1:0]   cbr_new, cbr_use, row_inc;
  logic [3:0]         nbits;
  logic [7:0]         pb_shift, data_byte;
  logic [2:0]         pad;
  logic [HeightW-1:0] bpr_wide;

  always_comb begin
    if (image_width_i == '0) begin
      w_eff = WidthW'(1);
    end else if (image_width_i > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = image_width_i;
    end
  end

  assign h_eff  = (image_height_i == '0) ? HeightW'(1) : image_height_i;
  assign bh_eff = (band_height_i == '0) ? BandW'(1) : band_height_i;

  assign luma_sum = LumaW'({pixel_i[15:11], 3'b000}) * LumaR
                  + LumaW'({pixel_i[10:5], 2'b00}) * LumaG
                  + LumaW'({pixel_i[4:0], 3'b000}) * LumaB;
  assign black = luma_sum < BlackLimit;

  assign pixel_stall_o = full_i;
  assign accept = pixel_valid_i && !full_i;
  assign start  = (row_q == '0) && (col_q == '0);

  assign rows_base = (start && (rows_done_q >= h_eff)) ? '0 : rows_done_q;
  assign remaining = h_eff - rows_base;
  assign cbr_new   = (remaining < {4'b0000, bh_eff}) ? remaining[BandW-1:0] : bh_eff;
  assign cbr_use   = start ? cbr_new : cbr_q;
  assign bpr_wide  = ({1'b0, w_eff} + HeightW'(7)) >> 3;

  assign nbits    = {1'b0, bits_q} + 4'd1;
  assign row_end  = ({1'b0, col_q} + WidthW'(1)) >= w_eff;
  assign emit     = nbits[3] || row_end;
  assign pb_shift = {pack_q[6:0], black};
  assign pad      = 3'(4'd8 - nbits);
  assign data_byte = pb_shift << pad;

  assign rows_inc = rows_base + HeightW'(1);
  assign row_inc  = row_q + BandW'(1);
  assign ie = row_end && ((rows_inc >= h_eff) || (rows_inc == '0));
  assign be = ie || (row_end && ((row_inc >= cbr_use) || (row_inc == '0)));

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    rows_done_d = rows_done_q;
    cbr_d       = cbr_q;
    pack_d      = pack_q;
    bits_d      = bits_q;
    if (accept) begin
      cbr_d = cbr_use;
      if (row_end) begin
        col_d       = '0;
        rows_done_d = ie ? '0 : rows_inc;
        row_d       = be ? '0 : row_inc;
      end else begin
        col_d       = col_q + ColW'(1);
        rows_done_d = rows_base;
      end
      pack_d = emit ? '0 : pb_shift;
      bits_d = emit ? '0 : nbits[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      rows_done_q <= '0;
      cbr_q       <= '0;
      pack_q      <= '0;
      bits_q      <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      rows_done_q <= rows_done_d;
      cbr_q       <= cbr_d;
      pack_q      <= pack_d;
      bits_q      <= bits_d;
    end
  end

  assign push_o            = accept && (start || emit);
  assign entry_o.hdr       = start;
  assign entry_o.bpr       = bpr_wide[7:0];
  assign entry_o.rows      = cbr_new;
  assign entry_o.dat       = emit;
  assign entry_o.data      = data_byte;
  assign entry_o.band_end  = be;
  assign entry_o.image_end = ie;

  // a row always starts on a fresh byte
  a_row_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q == '0) |-> (bits_q == '0 && pack_q == '0))
    else $error("pack state not clear at row start");

endmodule
`default_nettype wire

>>> rtl/rmrb_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrb_fifo
// Short request queue between the pixel front end and the byte emitter.
// ----------------------------------------------------------------------------
module rmrb_fifo import rmrb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire rmrb_entry_t wdata_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output rmrb_entry_t      rdata_o
);

  rmrb_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> rtl/rmrb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmrb_back
// Expands queued requests into header and data bytes into an output register.
// ----------------------------------------------------------------------------
module rmrb_back import rmrb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  wire rmrb_entry_t entry_i,
  output logic             pop_o,
  output logic [7:0]       out_byte_o,
  output logic             band_end_o,
  output logic             image_end_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i
);

  logic [3:0] hcnt_q, hcnt_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       be_q, be_d, ie_q, ie_d;
  logic       load, in_hdr;
  logic [7:0] hdr_byte;

  assign load   = !empty_i && (!vld_q || !out_stall_i);
  assign in_hdr = entry_i.hdr && (hcnt_q != HdrLen);

  always_comb begin
    case (hdr_byte_e'(hcnt_q[2:0]))
      HB_GS:   hdr_byte = HdrGs;
      HB_V:    hdr_byte = HdrV;
      HB_MODE: hdr_byte = HdrMode;
      HB_M:    hdr_byte = HdrZero;
      HB_XL:   hdr_byte = entry_i.bpr;
      HB_XH:   hdr_byte = HdrZero;
      HB_YL:   hdr_byte = entry_i.rows;
      HB_YH:   hdr_byte = HdrZero;
      default: hdr_byte = HdrZero;
    endcase
  end

  always_comb begin
    hcnt_d = hcnt_q;
    vld_d  = vld_q && out_stall_i;
    byte_d = byte_q;
    be_d   = be_q;
    ie_d   = ie_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = 1'b1;
      if (in_hdr) begin
        byte_d = hdr_byte;
        be_d   = 1'b0;
        ie_d   = 1'b0;
        if ((hcnt_q == HdrLen - 4'd1) && !entry_i.dat) begin
          pop_o  = 1'b1;
          hcnt_d = '0;
        end else begin
          hcnt_d = hcnt_q + 4'd1;
        end
      end else begin
        byte_d = entry_i.data;
        be_d   = entry_i.band_end;
        ie_d   = entry_i.image_end;
        pop_o  = 1'b1;
        hcnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      hcnt_q <= hcnt_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    be_q   <= be_d;
    ie_q   <= ie_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign band_end_o  = be_q;
  assign image_end_o = ie_q;

  // mid-header position only while the header request is still queued
  a_hdr_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hcnt_q != '0) |-> (!empty_i && entry_i.hdr && hcnt_q <= HdrLen))
    else $error("header position without header request");

  a_image_ends_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && ie_q) |-> be_q)
    else $error("image end without band end");

endmodule
`default_nettype wire

>>> tb/tb_rgb565_to_mono_raster_band.sv
// ----------------------------------------------------------------------------
// tb_rgb565_to_mono_raster_band
// Self-checking bench for the RGB565 to mono raster band encoder. Pixels are
// pushed through the valid/stall port while a local model of the band framing
// and dot packing predicts the byte stream. Every byte taken from the output
// port is compared with the oldest predicted byte. The run steps through
// register settings, idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_rgb565_to_mono_raster_band;
  import rmrb_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 10;

  typedef struct {
    logic [7:0] data;
    logic       band_end;
    logic       image_end;
  } stream_byte_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic [PixW-1:0] pixel_i;
  logic            pixel_valid_i;
  logic            pixel_stall_o;
  logic [7:0]      out_byte_o;
  logic            band_end_o;
  logic            image_end_o;
  logic            out_valid_o;
  logic            out_stall_i;

  // model of the encoder
  logic [WidthW-1:0]  img_width;
  logic [HeightW-1:0] img_height;
  logic [BandW-1:0]   band_max;
  int unsigned        dot_col;
  logic [7:0]         band_row;
  logic [11:0]        rows_sent;
  logic [7:0]         band_rows;
  logic [7:0]         dot_acc;
  int unsigned        dot_cnt;

  stream_byte_t exp_stream[$];

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_cycles;
  int cycles;
  int errors;
  int bytes_checked;
  int pixels_sent;
  int reg_writes;

  rgb565_to_mono_raster_band u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_i       (pixel_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .out_byte_o    (out_byte_o),
    .band_end_o    (band_end_o),
    .image_end_o   (image_end_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycles, exp_stream.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  function automatic void note_byte(logic [7:0] data, logic be, logic ie);
    stream_byte_t sb;
    sb.data = data;
    sb.band_end = be;
    sb.image_end = ie;
    exp_stream = {exp_stream, sb};
  endfunction

  function automatic void predict_pixel(logic [PixW-1:0] pix);
    int unsigned w, h, bh, bpr, luma, nbits;
    logic dot, row_end, be, ie;
    logic [7:0] data;
    w = img_width;
    if (w == 0) w = 1;
    else if (w > MaxWidth) w = MaxWidth;
    h = (img_height == 0) ? 1 : img_height;
    bh = (band_max == 0) ? 1 : band_max;
    if (band_row == 0 && dot_col == 0) begin
      if (rows_sent >= h) rows_sent = '0;
      band_rows = ((h - rows_sent) < bh) ? 8'(h - rows_sent) : 8'(bh);
      bpr = (w + 7) / 8;
      note_byte(HdrGs, 1'b0, 1'b0);
      note_byte(HdrV, 1'b0, 1'b0);
      note_byte(HdrMode, 1'b0, 1'b0);
      note_byte(HdrZero, 1'b0, 1'b0);
      note_byte(8'(bpr), 1'b0, 1'b0);
      note_byte(8'(bpr >> 8), 1'b0, 1'b0);
      note_byte(band_rows, 1'b0, 1'b0);
      note_byte(HdrZero, 1'b0, 1'b0);
    end
    luma = (299 * (8 * pix[15:11]) + 587 * (4 * pix[10:5]) + 114 * (8 * pix[4:0])) / 1000;
    dot = (luma < 128);
    nbits = dot_cnt + 1;
    row_end = (dot_col + 1) >= w;
    dot_acc = {dot_acc[6:0], dot};
    if (nbits >= 8 || row_end) begin
      data = dot_acc << (8 - nbits);
      be = 1'b0;
      ie = 1'b0;
      if (row_end) begin
        dot_col = 0;
        rows_sent = rows_sent + 12'd1;
        band_row = band_row + 8'd1;
        if (rows_sent >= h || rows_sent == 0) begin
          be = 1'b1;
          ie = 1'b1;
          rows_sent = '0;
          band_row = '0;
        end else if (band_row >= band_rows || band_row == 0) begin
          be = 1'b1;
          band_row = '0;
        end
      end else begin
        dot_col++;
      end
      note_byte(data, be, ie);
      dot_acc = '0;
      dot_cnt = 0;
    end else begin
      dot_col++;
      dot_cnt = nbits;
    end
  endfunction

  // output port: a byte is taken at the next rising edge if valid and not stalled
  always @(negedge clk_i) begin
    stream_byte_t sb;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_checked++;
      if (exp_stream.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected byte %02h be %0b ie %0b", out_byte_o, band_end_o, image_end_o);
      end else begin
        sb = exp_stream.pop_front();
        if (out_byte_o !== sb.data || band_end_o !== sb.band_end ||
            image_end_o !== sb.image_end) begin
          errors++;
          if (errors <= 10)
            $display("byte mismatch: exp %02h be %0b ie %0b, got %02h be %0b ie %0b",
                     sb.data, sb.band_end, sb.image_end,
                     out_byte_o, band_end_o, image_end_o);
        end
      end
    end
  end

  // called at a rising edge; leaves valid high after the request is taken
  task automatic send_pixel(logic [PixW-1:0] pix);
    logic taken;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      pixel_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    pixel_i <= pix;
    pixel_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = !pixel_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_pixel(pix);
    pixels_sent++;
  endtask

  task automatic wait_drain();
    pixel_valid_i <= 1'b0;
    while (exp_stream.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH:  img_width = val[WidthW-1:0];
      REG_IMAGE_HEIGHT: img_height = val[HeightW-1:0];
      REG_BAND_HEIGHT:  band_max = val[BandW-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // unused upper data bits are randomized
  task automatic set_geometry(int w, int h, int b);
    write_reg(REG_IMAGE_WIDTH, {1'($urandom), 11'(w)});
    write_reg(REG_IMAGE_HEIGHT, 12'(h));
    write_reg(REG_BAND_HEIGHT, {4'($urandom), 8'(b)});
  endtask

  task automatic test_pixel_extremes();
    // reset geometry; gray levels straddle the black threshold
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    send_pixel(16'h8410);
    send_pixel(16'h7BEF);
    send_pixel(16'h8430);
  endtask

  task automatic test_register_extremes();
    // zero width, height and band act as one
    wait_drain();
    set_geometry(0, 0, 0);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    // oversized width clamps, tallest band
    wait_drain();
    set_geometry(2047, 4095, 255);
    repeat (4) send_pixel(16'($urandom));
    // width shrinks mid row
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    send_pixel(16'h0000);
    // height shrinks to the number of rows already sent
    wait_drain();
    write_reg(REG_IMAGE_HEIGHT, 12'd1);
    repeat (3) send_pixel(16'($urandom));
  endtask

  task automatic test_image_restart();
    // band ends mid image, then height drops so the next band restarts the image
    wait_drain();
    set_geometry(2, 4, 2);
    repeat (4) send_pixel(16'($urandom));
    wait_drain();
    write_reg(REG_IMAGE_HEIGHT, 12'd2);
    repeat (2) send_pixel(16'($urandom));
  endtask

  task automatic test_random_phases();
    int w, sel;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      sel = $urandom_range(0, 9);
      if (sel == 0) w = 0;
      else if (sel < 8) w = $urandom_range(1, 20);
      else w = $urandom_range(21, 40);
      set_geometry(w, $urandom_range(0, 6), $urandom_range(0, 4));
      repeat (40) send_pixel(16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_output_holdoff();
    wait_drain();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_geometry(16, 3, 2);
    hold_cycles = 80;
    repeat (30) send_pixel(16'($urandom_range(0, 65535)));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_IMAGE_WIDTH;
    cfg_data_i = '0;
    pixel_i = '0;
    pixel_valid_i = 1'b0;
    out_stall_i = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    cycles = 0;
    errors = 0;
    bytes_checked = 0;
    pixels_sent = 0;
    reg_writes = 0;
    img_width = WidthReset;
    img_height = HeightReset;
    band_max = BandReset;
    dot_col = 0;
    band_row = '0;
    rows_sent = '0;
    band_rows = '0;
    dot_acc = '0;
    dot_cnt = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pixel_extremes();
    test_register_extremes();
    test_image_restart();
    test_random_phases();
    test_output_holdoff();
    wait_drain();

    $display("%0d pixels sent, %0d stream bytes checked, %0d register writes", pixels_sent,
             bytes_checked, reg_writes);
    $display("geometry extremes, mid-image register changes, stall phases and hold-off done");
    if (errors == 0 && exp_stream.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d bytes outstanding", errors, exp_stream.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
